// ----- src/hcbm_pkg.sv -----
`timescale 1ns / 1ps
package hcbm_pkg;
    localparam int MAX_COLS    = 128;
    localparam int MAX_ROWS    = 128;
    localparam int NUM_RADII   = 4;
    localparam int COUNT_WIDTH = 16;
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int RAD_W  = (NUM_RADII > 1) ? $clog2(NUM_RADII) : 1;
    localparam int ADDR_W = RAD_W + ROW_W + COL_W;
    localparam int DEPTH  = NUM_RADII * MAX_ROWS * MAX_COLS;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [10:0] SLOPE_Q8  = 11'd1487;
    localparam logic [10:0] OFFSET_Q8 = 11'd1229;

    localparam logic [0:0] OP_VOTE   = 1'b0;
    localparam logic [0:0] OP_FINISH = 1'b1;

    localparam logic [2:0] REG_COLS = 3'd0;
    localparam logic [2:0] REG_ROWS = 3'd1;
    localparam logic [2:0] REG_SCALE = 3'd2;
    localparam logic [2:0] REG_THR  = 3'd3;
    localparam logic [2:0] REG_RAD0 = 3'd4;
    localparam logic [2:0] REG_RAD1 = 3'd5;
    localparam logic [2:0] REG_RAD2 = 3'd6;
    localparam logic [2:0] REG_RAD3 = 3'd7;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCALE, S_CIRC, S_OCT, S_RMW, S_STEP,
        S_SCAN, S_SCANCMP, S_THR1, S_THR2, S_OUT
    } t_state;
endpackage

// ----- src/hcbm_if.sv -----
`timescale 1ns / 1ps
interface hcbm_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
    modport source (output valid, operation, pixel_x, pixel_y, input ready);
    modport sink (input valid, operation, pixel_x, pixel_y, output ready);
endinterface

interface hcbm_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [6:0]  best_x;
    logic [6:0]  best_y;
    logic [1:0]  best_index;
    logic [15:0] best_votes;
    modport source (output valid, found, best_x, best_y, best_index, best_votes,
                    input ready);
    modport sink (input valid, found, best_x, best_y, best_index, best_votes,
                  output ready);
endinterface

// ----- src/hcbm_ram.sv -----
`timescale 1ns / 1ps
module hcbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ----- src/hough_circle_best_match_top.sv -----
`timescale 1ns / 1ps
// Vote item: x then y scaling, then per radius a setup step, and per midpoint step an advance (S_STEP)
//   plus a read (S_OCT) and a write back (S_RMW) for each of the eight octant points inside the store.
// Finish item: the result is registered after a scan of rows*cols*NUM_RADII cells (no scan if the
//   geometry is empty), then a clearing sweep of all 65536 cells runs before the next item.
// Results wait in an output register; no new item is taken until it is gone.
// Reset: synchronous; a clearing pass over all 65536 cells of the store runs before the first item.
module hough_circle_best_match_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcbm_in_if.sink     in_ch,
    hcbm_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hcbm_pkg::*;

    // configuration registers
    logic [7:0] r_cols, r_rows;
    logic [8:0] r_scale, r_thr;
    logic [9:0] r_rad [4];
    logic [2:0] w_reg;
    assign w_reg  = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 8'd128; r_rows <= 8'd128; r_scale <= 9'd256; r_thr <= 9'd128;
            r_rad[0] <= 10'd8; r_rad[1] <= 10'd16; r_rad[2] <= 10'd24; r_rad[3] <= 10'd32;
        end else if (psel && penable && pwrite) begin
            case (w_reg)
                REG_COLS:  r_cols  <= pwdata[7:0];
                REG_ROWS:  r_rows  <= pwdata[7:0];
                REG_SCALE: r_scale <= pwdata[8:0];
                REG_THR:   r_thr   <= pwdata[8:0];
                REG_RAD0:  r_rad[0] <= pwdata[9:0];
                REG_RAD1:  r_rad[1] <= pwdata[9:0];
                REG_RAD2:  r_rad[2] <= pwdata[9:0];
                REG_RAD3:  r_rad[3] <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_COLS:  prdata = {24'd0, r_cols};
            REG_ROWS:  prdata = {24'd0, r_rows};
            REG_SCALE: prdata = {23'd0, r_scale};
            REG_THR:   prdata = {23'd0, r_thr};
            REG_RAD0:  prdata = {22'd0, r_rad[0]};
            REG_RAD1:  prdata = {22'd0, r_rad[1]};
            REG_RAD2:  prdata = {22'd0, r_rad[2]};
            REG_RAD3:  prdata = {22'd0, r_rad[3]};
            default:   prdata = '0;
        endcase
    end

    // effective geometry
    logic [COL_W:0] w_cols;
    logic [ROW_W:0] w_rows;
    assign w_cols = (r_cols > 8'(MAX_COLS)) ? (COL_W+1)'(MAX_COLS) : (COL_W+1)'(r_cols);
    assign w_rows = (r_rows > 8'(MAX_ROWS)) ? (ROW_W+1)'(MAX_ROWS) : (ROW_W+1)'(r_rows);

    // state
    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_addr, n_addr;          // clear sweep / scan cursor
    logic [10:0] r_xc, n_xc, r_yc, n_yc;        // scaled centre
    logic [RAD_W-1:0] r_ri, n_ri;
    logic signed [12:0] r_a, n_a, r_b, n_b, r_d, n_d;
    logic [2:0] r_oct, n_oct;
    logic [ADDR_W-1:0] r_vaddr, n_vaddr;
    logic [COUNT_WIDTH-1:0] r_best, n_best;
    logic [ADDR_W-1:0] r_baddr, n_baddr;
    logic r_any, n_any;
    logic [ADDR_W-1:0] r_paddr, n_paddr;        // address read last cycle during scan
    logic r_pvalid, n_pvalid;
    logic [19:0] r_prod, n_prod;                // shared multiplier result
    logic r_found, n_found;
    logic r_ovalid, n_ovalid;

    // shared multiplier
    logic [13:0] w_ma;
    logic [10:0] w_mb;
    logic [24:0] w_mp;
    assign w_mp = w_ma * w_mb;

    // RAM
    logic w_we;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [COUNT_WIDTH-1:0] w_wdata, w_rdata;
    hcbm_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata));

    // octant point
    logic signed [12:0] w_dx, w_dy, w_px, w_py;
    logic w_inb;
    always_comb begin
        case (r_oct)
            3'd0: begin w_dx = r_a;  w_dy = r_b;  end
            3'd1: begin w_dx = -r_a; w_dy = r_b;  end
            3'd2: begin w_dx = r_a;  w_dy = -r_b; end
            3'd3: begin w_dx = -r_a; w_dy = -r_b; end
            3'd4: begin w_dx = r_b;  w_dy = r_a;  end
            3'd5: begin w_dx = -r_b; w_dy = r_a;  end
            3'd6: begin w_dx = r_b;  w_dy = -r_a; end
            default: begin w_dx = -r_b; w_dy = -r_a; end
        endcase
        w_px = $signed({2'b00, r_xc}) + w_dx;
        w_py = $signed({2'b00, r_yc}) + w_dy;
        w_inb = !w_px[12] && !w_py[12] && (w_px < $signed({1'b0, 4'd0, w_cols}))
                && (w_py < $signed({1'b0, 4'd0, w_rows}));
    end

    // scan counter is kept as {row, col, radius}; RAM address is {radius, row, col}
    logic [RAD_W-1:0] w_si;
    assign w_si = r_addr[0 +: RAD_W];
    logic [ADDR_W-1:0] w_scan_ram;
    assign w_scan_ram = {r_addr[0 +: RAD_W], r_addr[RAD_W+COL_W +: ROW_W],
                         r_addr[RAD_W +: COL_W]};

    assign in_ch.ready = (r_state == S_IDLE) && !r_ovalid;

    always_comb begin
        n_state = r_state; n_addr = r_addr; n_xc = r_xc; n_yc = r_yc; n_ri = r_ri;
        n_a = r_a; n_b = r_b; n_d = r_d; n_oct = r_oct; n_vaddr = r_vaddr;
        n_best = r_best; n_baddr = r_baddr; n_any = r_any; n_paddr = r_paddr;
        n_pvalid = 1'b0; n_prod = r_prod; n_found = r_found;
        n_ovalid = r_ovalid && !out_ch.ready;
        w_we = 1'b0; w_waddr = r_addr; w_wdata = '0; w_raddr = r_vaddr;
        w_ma = '0; w_mb = '0;
        case (r_state)
            S_CLEAR: begin
                // sweep zero through every cell
                w_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_ch.valid && in_ch.ready) begin
                    if (in_ch.operation == OP_FINISH) begin
                        n_addr = '0; n_best = '0; n_baddr = '0; n_any = 1'b0;
                        n_state = (w_cols == 0 || w_rows == 0) ? S_OUT : S_SCAN;
                    end else begin
                        n_xc = {1'b0, in_ch.pixel_x}; n_yc = {1'b0, in_ch.pixel_y};
                        n_oct = '0;
                        n_state = S_SCALE;
                    end
                end
            end
            S_SCALE: begin
                // scale x then y through the multiplier
                w_mb = {2'b0, r_scale};
                if (r_oct == 3'd0) begin
                    w_ma = {4'd0, r_xc[9:0]};
                    n_xc = w_mp[18:8]; n_oct = 3'd1;
                end else begin
                    w_ma = {4'd0, r_yc[9:0]};
                    n_yc = w_mp[18:8]; n_oct = '0; n_ri = '0; n_state = S_CIRC;
                end
            end
            S_CIRC: begin
                // scale radius and start the midpoint circle
                w_ma = {4'd0, r_rad[r_ri]}; w_mb = {2'b0, r_scale};
                n_a = '0; n_b = 13'(w_mp[18:8]);
                n_d = 13'sd1 - $signed(13'(w_mp[18:8]));
                n_oct = '0; n_state = S_OCT;
            end
            S_OCT: begin
                // read cell of this octant point, or skip it
                n_vaddr = {r_ri, w_py[ROW_W-1:0], w_px[COL_W-1:0]};
                w_raddr = {r_ri, w_py[ROW_W-1:0], w_px[COL_W-1:0]};
                if (w_inb) begin
                    n_state = S_RMW;
                end else if (r_oct == 3'd7) begin
                    n_state = S_STEP;
                end else begin
                    n_oct = r_oct + 1'b1;
                end
            end
            S_RMW: begin
                // saturating increment
                w_we = 1'b1; w_waddr = r_vaddr;
                w_wdata = (w_rdata == COUNT_MAX) ? w_rdata : w_rdata + 1'b1;
                if (r_oct == 3'd7) begin
                    n_state = S_STEP;
                end else begin
                    n_oct = r_oct + 1'b1; n_state = S_OCT;
                end
            end
            S_STEP: begin
                // advance the midpoint loop or the radius
                n_oct = '0;
                if (r_a < r_b) begin
                    n_a = r_a + 1'b1;
                    if (r_d[12]) begin
                        n_d = r_d + 13'sd2 * (r_a + 1'b1) + 13'sd1;
                    end else begin
                        n_b = r_b - 1'b1;
                        n_d = r_d + 13'sd2 * ((r_a + 1'b1) - (r_b - 1'b1)) + 13'sd1;
                    end
                    n_state = S_OCT;
                end else if (r_ri == RAD_W'(NUM_RADII - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_ri = r_ri + 1'b1; n_state = S_CIRC;
                end
            end
            S_SCAN: begin
                // stream reads; compare the one that returns
                w_raddr = w_scan_ram;
                n_paddr = w_scan_ram; n_pvalid = 1'b1;
                if (r_pvalid && w_rdata > r_best) begin
                    n_best = w_rdata; n_baddr = r_paddr; n_any = 1'b1;
                end
                if (w_si == RAD_W'(NUM_RADII - 1) || NUM_RADII == 1) begin
                    n_addr[0 +: RAD_W] = '0;
                    if (r_addr[RAD_W +: COL_W] == COL_W'(w_cols - 1'b1)) begin
                        n_addr[RAD_W +: COL_W] = '0;
                        n_addr[RAD_W+COL_W +: ROW_W] = r_addr[RAD_W+COL_W +: ROW_W] + 1'b1;
                        if (r_addr[RAD_W+COL_W +: ROW_W] == ROW_W'(w_rows - 1'b1)) begin
                            n_state = S_SCANCMP;
                        end
                    end else begin
                        n_addr[RAD_W +: COL_W] = r_addr[RAD_W +: COL_W] + 1'b1;
                    end
                end else begin
                    n_addr[0 +: RAD_W] = r_addr[0 +: RAD_W] + 1'b1;
                end
            end
            S_SCANCMP: begin
                if (r_pvalid && w_rdata > r_best) begin
                    n_best = w_rdata; n_baddr = r_paddr; n_any = 1'b1;
                end
                n_state = S_THR1;
            end
            S_THR1: begin
                // scaled radius of the winner
                w_ma = {4'd0, r_rad[r_baddr[COL_W+ROW_W +: RAD_W]]}; w_mb = {2'b0, r_scale};
                n_prod = {9'd0, w_mp[18:8]};
                n_state = S_THR2;
            end
            S_THR2: begin
                // expected votes, rounded
                w_ma = {3'd0, r_prod[10:0]}; w_mb = SLOPE_Q8;
                n_prod = 20'((w_mp + 25'(OFFSET_Q8) + 25'd128) >> 8);
                n_state = S_OUT;
                n_found = 1'b0;
                n_xc = '0;
            end
            S_OUT: begin
                // relative threshold and compare
                w_ma = r_prod[13:0]; w_mb = {2'b0, r_thr};
                n_found = r_any && ({16'd0, r_best} >= 32'(w_mp >> 8));
                n_ovalid = 1'b1;
                n_addr = '0;
                n_state = S_CLEAR;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_addr <= '0; r_ovalid <= 1'b0; r_pvalid <= 1'b0;
        end else begin
            r_state <= n_state; r_addr <= n_addr; r_ovalid <= n_ovalid;
            r_pvalid <= n_pvalid;
        end
        r_xc <= n_xc; r_yc <= n_yc; r_ri <= n_ri; r_a <= n_a; r_b <= n_b; r_d <= n_d;
        r_oct <= n_oct; r_vaddr <= n_vaddr; r_best <= n_best; r_baddr <= n_baddr;
        r_any <= n_any; r_paddr <= n_paddr; r_prod <= n_prod; r_found <= n_found;
    end

    assign out_ch.valid      = r_ovalid;
    assign out_ch.found      = r_found;
    assign out_ch.best_x     = 7'(r_baddr[COL_W-1:0]);
    assign out_ch.best_y     = 7'(r_baddr[COL_W +: ROW_W]);
    assign out_ch.best_index = 2'(r_baddr[COL_W+ROW_W +: RAD_W]);
    assign out_ch.best_votes = 16'(r_best);
endmodule

// ----- tb/sv/tb_hough_circle_best_match_top.sv -----
`timescale 1ns / 1ps
module tb_hough_circle_best_match_top;
    import hcbm_pkg::*;

    typedef struct packed {
        logic        found;
        logic [6:0]  best_x;
        logic [6:0]  best_y;
        logic [1:0]  best_index;
        logic [15:0] best_votes;
    } circle_hit_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  reg_idx;
        logic [9:0]  reg_val;
        logic [0:0]  op;
        logic [9:0]  px;
        logic [9:0]  py;
        bit          typed;
        circle_hit_t hit;
    } stim_row_t;

    localparam int SETTLE_CYCLES = 70000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hcbm_in_if  in_ch ();
    hcbm_out_if out_ch ();

    hough_circle_best_match_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the accumulator and the register file
    int unsigned vote_store [NUM_RADII*MAX_ROWS*MAX_COLS];
    int unsigned cols_q, rows_q, scale_q, thr_q;
    int unsigned radius_q [4];

    circle_hit_t pending_hits[$];
    int          error_count;
    int          votes_sent;
    int          finishes_sent;
    int          hits_seen;
    int          send_gap;
    int          recv_stall;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #2_000_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int scaled(int unsigned v);
        return int'((v * scale_q) >> 8);
    endfunction

    function automatic void cast_vote(int plane, int cx, int cy);
        int unsigned c_lim;
        int unsigned r_lim;
        int unsigned idx;
        c_lim = (cols_q > MAX_COLS) ? MAX_COLS : cols_q;
        r_lim = (rows_q > MAX_ROWS) ? MAX_ROWS : rows_q;
        if (cx < 0 || cy < 0 || cx >= int'(c_lim) || cy >= int'(r_lim)) return;
        idx = (plane * MAX_ROWS + cy) * MAX_COLS + cx;
        if (vote_store[idx] < COUNT_MAX) vote_store[idx]++;
    endfunction

    function automatic void plot_eight(int plane, int xc, int yc, int a, int b);
        cast_vote(plane, xc + a, yc + b);
        cast_vote(plane, xc - a, yc + b);
        cast_vote(plane, xc + a, yc - b);
        cast_vote(plane, xc - a, yc - b);
        cast_vote(plane, xc + b, yc + a);
        cast_vote(plane, xc - b, yc + a);
        cast_vote(plane, xc + b, yc - a);
        cast_vote(plane, xc - b, yc - a);
    endfunction

    // Midpoint circle around one scaled edge pixel
    function automatic void draw_ring(int plane, int xc, int yc, int rs);
        int a;
        int b;
        int d;
        a = 0;
        b = rs;
        d = 1 - rs;
        plot_eight(plane, xc, yc, a, b);
        while (a < b) begin
            a++;
            if (d < 0) begin
                d += 2 * a + 1;
            end else begin
                b--;
                d += 2 * (a - b) + 1;
            end
            plot_eight(plane, xc, yc, a, b);
        end
    endfunction

    function automatic void apply_vote(logic [9:0] px, logic [9:0] py);
        for (int r = 0; r < NUM_RADII; r++)
            draw_ring(r, scaled(px), scaled(py), scaled(radius_q[r]));
    endfunction

    // Scan for the first strict maximum, test it and clear the store
    function automatic circle_hit_t best_circle();
        circle_hit_t h;
        int unsigned best;
        int unsigned c_lim;
        int unsigned r_lim;
        int unsigned v;
        longint unsigned rs;
        longint unsigned expv;
        longint unsigned thr;
        h = '0;
        best = 0;
        c_lim = (cols_q > MAX_COLS) ? MAX_COLS : cols_q;
        r_lim = (rows_q > MAX_ROWS) ? MAX_ROWS : rows_q;
        for (int y = 0; y < int'(r_lim); y++)
            for (int x = 0; x < int'(c_lim); x++)
                for (int r = 0; r < NUM_RADII; r++) begin
                    v = vote_store[(r * MAX_ROWS + y) * MAX_COLS + x];
                    if (v > best) begin
                        best = v;
                        h.best_x = 7'(x);
                        h.best_y = 7'(y);
                        h.best_index = 2'(r);
                    end
                end
        if (best > 0) begin
            rs = scaled(radius_q[h.best_index]);
            expv = (longint'(SLOPE_Q8) * rs + OFFSET_Q8 + 128) >> 8;
            thr = (expv * thr_q) >> 8;
            h.found = (best >= thr);
        end
        h.best_votes = best[15:0];
        foreach (vote_store[i]) vote_store[i] = 0;
        return h;
    endfunction

    function automatic void shadow_reset();
        foreach (vote_store[i]) vote_store[i] = 0;
        cols_q = 128;
        rows_q = 128;
        scale_q = 256;
        thr_q = 128;
        radius_q = '{8, 16, 24, 32};
    endfunction

    // Receiver stalls
    always @(negedge i_clk) begin
        if (i_rst_n) out_ch.ready = ($urandom_range(0, 99) >= recv_stall);
    end

    // Result checker
    always @(posedge i_clk) begin
        circle_hit_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            hits_seen++;
            if (pending_hits.size() == 0) begin
                $error("result with nothing expected");
                error_count++;
            end else begin
                want = pending_hits.pop_front();
                if (out_ch.found !== want.found) begin
                    $error("found: expected %0d got %0d", want.found, out_ch.found);
                    error_count++;
                end
                if (out_ch.best_x !== want.best_x) begin
                    $error("best_x: expected %0d got %0d", want.best_x, out_ch.best_x);
                    error_count++;
                end
                if (out_ch.best_y !== want.best_y) begin
                    $error("best_y: expected %0d got %0d", want.best_y, out_ch.best_y);
                    error_count++;
                end
                if (out_ch.best_index !== want.best_index) begin
                    $error("best_index: expected %0d got %0d", want.best_index,
                           out_ch.best_index);
                    error_count++;
                end
                if (out_ch.best_votes !== want.best_votes) begin
                    $error("best_votes: expected %0d got %0d", want.best_votes,
                           out_ch.best_votes);
                    error_count++;
                end
            end
        end
    end

    // Hold off until every result is back and the clearing sweep is done
    task automatic settle();
        in_ch.valid = 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [9:0] val);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = {22'd0, val};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_COLS:  cols_q = val[7:0];
            REG_ROWS:  rows_q = val[7:0];
            REG_SCALE: scale_q = val[8:0];
            REG_THR:   thr_q = val[8:0];
            default:   radius_q[idx - REG_RAD0] = val;
        endcase
    endtask

    // Drive one item; valid stays high until the next item or a hold-off
    task automatic send_item(logic [0:0] op, logic [9:0] px, logic [9:0] py,
                             bit typed, circle_hit_t typed_hit);
        circle_hit_t h;
        if ($urandom_range(0, 99) < send_gap) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.operation = op;
        in_ch.pixel_x = px;
        in_ch.pixel_y = py;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (op == OP_VOTE) begin
            apply_vote(px, py);
            votes_sent++;
        end else begin
            h = best_circle();
            if (typed && h !== typed_hit) begin
                $error("predictor: expected %h got %h", typed_hit, h);
                error_count++;
            end
            pending_hits.push_back(typed ? typed_hit : h);
            finishes_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic random_config(bit widest);
        int unsigned pick;
        settle();
        write_reg(REG_COLS, widest ? 10'd128 : 10'($urandom_range(1, 48)));
        write_reg(REG_ROWS, widest ? 10'd128 : 10'($urandom_range(1, 48)));
        pick = $urandom_range(0, 3);
        write_reg(REG_SCALE, pick == 0 ? 10'd256 : pick == 1 ? 10'd128 :
                             pick == 2 ? 10'd32 : 10'($urandom_range(1, 511)));
        write_reg(REG_THR, 10'($urandom_range(0, 511)));
        for (int r = 0; r < 4; r++)
            write_reg(3'(int'(REG_RAD0) + r), widest && r == 3 ? 10'd1023 :
                      10'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) >> 4
                                                      : $urandom_range(0, 40)));
        if (widest) write_reg(REG_SCALE, 10'd16);
    endtask

    // Random votes, mostly points on a circle of a configured radius
    task automatic random_phase(int n_items);
        int unsigned span;
        int          cx;
        int          cy;
        int          px;
        int          py;
        real         rr;
        real         ang;
        span = (scale_q == 0) ? 1023 : (((cols_q > rows_q ? cols_q : rows_q) * 256) / scale_q);
        if (span > 1023) span = 1023;
        cx = $urandom_range(0, span);
        cy = $urandom_range(0, span);
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 29) == 0) begin
                send_item(OP_FINISH, 10'($urandom), 10'($urandom), 1'b0, '0);
                cx = $urandom_range(0, span);
                cy = $urandom_range(0, span);
            end else if ($urandom_range(0, 9) < 7) begin
                rr = radius_q[$urandom_range(0, 3)];
                ang = $urandom_range(0, 6283) / 1000.0;
                px = cx + $rtoi(rr * $cos(ang));
                py = cy + $rtoi(rr * $sin(ang));
                px = px < 0 ? 0 : px > 1023 ? 1023 : px;
                py = py < 0 ? 0 : py > 1023 ? 1023 : py;
                send_item(OP_VOTE, 10'(px), 10'(py), 1'b0, '0);
            end else begin
                send_item(OP_VOTE, 10'($urandom), 10'($urandom), 1'b0, '0);
            end
        end
        send_item(OP_FINISH, 10'($urandom), 10'($urandom), 1'b0, '0);
    endtask

    // Directed stimulus: reset state, extremes and the corner cases
    stim_row_t directed [] = '{
        '{ROW_ITEM, REG_COLS,  0,    OP_FINISH, 0,    0,    1'b1, '0},
        '{ROW_ITEM, REG_COLS,  0,    OP_VOTE,   0,    0,    1'b0, '0},
        '{ROW_ITEM, REG_COLS,  0,    OP_VOTE,   1023, 1023, 1'b0, '0},
        '{ROW_ITEM, REG_COLS,  0,    OP_VOTE,   64,   64,   1'b0, '0},
        '{ROW_ITEM, REG_COLS,  0,    OP_VOTE,   64,   64,   1'b0, '0},
        '{ROW_ITEM, REG_COLS,  0,    OP_FINISH, 1023, 1023, 1'b0, '0},
        '{ROW_REG,  REG_THR,   511,  OP_VOTE,   0,    0,    1'b0, '0},
        '{ROW_ITEM, REG_COLS,  0,    OP_VOTE,   10,   10,   1'b0, '0},
        '{ROW_ITEM, REG_COLS,  0,    OP_FINISH, 0,    0,    1'b0, '0},
        '{ROW_REG,  REG_COLS,  0,    OP_VOTE,   0,    0,    1'b0, '0},
        '{ROW_ITEM, REG_COLS,  0,    OP_VOTE,   5,    5,    1'b0, '0},
        '{ROW_ITEM, REG_COLS,  0,    OP_FINISH, 0,    0,    1'b1, '0},
        '{ROW_REG,  REG_COLS,  255,  OP_VOTE,   0,    0,    1'b0, '0},
        '{ROW_REG,  REG_ROWS,  200,  OP_VOTE,   0,    0,    1'b0, '0},
        '{ROW_REG,  REG_SCALE, 0,    OP_VOTE,   0,    0,    1'b0, '0},
        '{ROW_ITEM, REG_COLS,  0,    OP_VOTE,   1023, 1023, 1'b0, '0},
        '{ROW_ITEM, REG_COLS,  0,    OP_FINISH, 0,    0,    1'b1,
          '{1'b0, 7'd0, 7'd0, 2'd0, 16'd8}},
        '{ROW_REG,  REG_SCALE, 511,  OP_VOTE,   0,    0,    1'b0, '0},
        '{ROW_REG,  REG_RAD0,  0,    OP_VOTE,   0,    0,    1'b0, '0},
        '{ROW_REG,  REG_RAD1,  1,    OP_VOTE,   0,    0,    1'b0, '0},
        '{ROW_REG,  REG_RAD2,  3,    OP_VOTE,   0,    0,    1'b0, '0},
        '{ROW_REG,  REG_RAD3,  5,    OP_VOTE,   0,    0,    1'b0, '0},
        '{ROW_ITEM, REG_COLS,  0,    OP_VOTE,   20,   30,   1'b0, '0},
        '{ROW_REG,  REG_THR,   0,    OP_VOTE,   0,    0,    1'b0, '0},
        '{ROW_ITEM, REG_COLS,  0,    OP_FINISH, 0,    0,    1'b0, '0}
    };

    initial begin
        int wait_cycles;
        error_count = 0;
        votes_sent = 0;
        finishes_sent = 0;
        hits_seen = 0;
        send_gap = 0;
        recv_stall = 0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_VOTE;
        in_ch.pixel_x = '0;
        in_ch.pixel_y = '0;
        out_ch.ready = 1'b0;
        shadow_reset();
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table
        foreach (directed[i]) begin
            if (directed[i].kind == ROW_REG) begin
                settle();
                write_reg(directed[i].reg_idx, directed[i].reg_val);
            end else begin
                send_item(directed[i].op, directed[i].px, directed[i].py,
                          directed[i].typed, directed[i].hit);
            end
        end

        // Random phases under the three idling regimes
        for (int mode = 0; mode < 3; mode++) begin
            send_gap = (mode == 0) ? 6 : (mode == 1) ? 59 : 0;
            recv_stall = (mode == 0) ? 59 : (mode == 1) ? 6 : 0;
            for (int p = 0; p < 3; p++) begin
                random_config(mode == 2 && p == 0);
                random_phase(120);
            end
        end

        // Drain
        in_ch.valid = 1'b0;
        wait_cycles = 0;
        while (pending_hits.size() != 0 && wait_cycles < 2_000_000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (1000) @(posedge i_clk);
        if (pending_hits.size() != 0) begin
            $error("%0d results never arrived", pending_hits.size());
            error_count++;
        end

        $display("Covered %0d votes and %0d searches, %0d results checked.",
                 votes_sent, finishes_sent, hits_seen);
        $display("Geometry, scale, threshold and all radii varied across 9 random phases.");
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
src/hcbm_pkg.sv
src/hcbm_if.sv
src/hcbm_ram.sv
src/hough_circle_best_match_top.sv
tb/sv/tb_hough_circle_best_match_top.sv
